FILE: rtl/gou_pkg.sv
package gou_pkg;

	localparam int NUM_ELEMENTS = 1024;
	localparam int ADDR_W = $clog2(NUM_ELEMENTS);

	localparam logic [16:0] ONE_Q = 17'd65536;
	localparam logic [40:0] STEP_CAP = 41'h100_0000_0000;

	localparam logic [2:0] MODE_DESCENT  = 3'd0;
	localparam logic [2:0] MODE_MOMENTUM = 3'd1;
	localparam logic [2:0] MODE_ADAGRAD  = 3'd2;
	localparam logic [2:0] MODE_RMSPROP  = 3'd3;
	localparam logic [2:0] MODE_ADAM     = 3'd4;

	localparam logic [2:0] CFG_MODE = 3'd0;
	localparam logic [2:0] CFG_LR   = 3'd1;
	localparam logic [2:0] CFG_D1   = 3'd2;
	localparam logic [2:0] CFG_D2   = 3'd3;
	localparam logic [2:0] CFG_EPS  = 3'd4;
	localparam logic [2:0] CFG_INIT = 3'd5;

	typedef struct packed {
		logic [9:0]         element_index;
		logic signed [31:0] parameter_value;
		logic signed [31:0] gradient_value;
		logic [15:0]        step_number;
	} in_item_t;

	typedef struct packed {
		logic [9:0]         result_index;
		logic signed [31:0] updated_value;
	} out_item_t;

	typedef enum logic {
		OP_DIV  = 1'b0,
		OP_SQRT = 1'b1
	} ds_op_t;

	typedef struct packed {
		logic        start;
		ds_op_t      op;
		logic [63:0] num;
		logic [31:0] den;
	} ds_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} ds_rsp_t;

	function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

	function automatic logic [31:0] usat32(input logic [63:0] v);
		if (v > 64'h0000_0000_ffff_ffff) begin
			return 32'hffff_ffff;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

FILE: rtl/gou_ram.sv
module gou_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/gou_divsqrt.sv
// Shared iterative unit: restoring divide (64b / 32b) or floor square root of
// the top 48 bits of num. Four steps per cycle.
module gou_divsqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  gou_pkg::ds_req_t req,
	output gou_pkg::ds_rsp_t rsp
);
	import gou_pkg::*;

	localparam int STEPS = 4;
	localparam logic [3:0] DIV_LAST  = 4'(64 / STEPS - 1);
	localparam logic [3:0] SQRT_LAST = 4'(48 / 2 / STEPS - 1);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	ds_op_t      op_q;
	logic [63:0] x_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [31:0] den_q;

	logic [63:0] x_d;
	logic [33:0] rem_d;
	logic [31:0] root_d;
	logic [33:0] trial;

	always_comb begin
		x_d    = x_q;
		rem_d  = rem_q;
		root_d = root_q;
		trial  = '0;
		for (int i = 0; i < STEPS; i++) begin
			if (op_q == OP_DIV) begin
				rem_d = {rem_d[32:0], x_d[63]};
				x_d   = {x_d[62:0], 1'b0};
				if (rem_d >= {2'b00, den_q}) begin
					rem_d  = rem_d - {2'b00, den_q};
					x_d[0] = 1'b1;
				end
			end else begin
				rem_d = {rem_d[31:0], x_d[63:62]};
				x_d   = {x_d[61:0], 2'b00};
				trial = {root_d, 2'b01};
				if (rem_d >= trial) begin
					rem_d  = rem_d - trial;
					root_d = {root_d[30:0], 1'b1};
				end else begin
					root_d = {root_d[30:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == OP_DIV) ? DIV_LAST : SQRT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q   <= req.op;
			x_q    <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_d;
			rem_q  <= rem_d;
			root_q <= root_d;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = (op_q == OP_DIV) ? x_q : {32'b0, root_q};

endmodule

FILE: rtl/gradient_optimizer_update.sv
// One element at a time; next item accepted after the result transfer.
// Descent and momentum bypass the divide/root unit; adagrad and rmsprop use
// one square root plus one 64-bit divide (skipped on a zero denominator); adam
// uses one squaring step per exponent bit, up to 17, then three divides and one
// root (all skipped on a zero bias correction). The shared unit sets their rate.
// Reset: registers take their reset values, then a sweep over all 1024 entries
// clears the seen flags with in_ready low; config writes are taken throughout.
module gradient_optimizer_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gou_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output gou_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import gou_pkg::*;

	typedef enum logic [11:0] {
		S_CLR  = 12'b0000_0000_0001,
		S_IDLE = 12'b0000_0000_0010,
		S_RD   = 12'b0000_0000_0100,
		S_MUL  = 12'b0000_0000_1000,
		S_SUM  = 12'b0000_0001_0000,
		S_WB   = 12'b0000_0010_0000,
		S_POW  = 12'b0000_0100_0000,
		S_DIV1 = 12'b0000_1000_0000,
		S_DIV2 = 12'b0001_0000_0000,
		S_SQRT = 12'b0010_0000_0000,
		S_DIVQ = 12'b0100_0000_0000,
		S_OUT  = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic start_q;

	// config
	logic [2:0]  mode_q;
	logic [31:0] lr_q;
	logic [16:0] d1_q, d2_q;
	logic [15:0] eps_q;
	logic [30:0] init_q;

	// item
	logic [9:0]         idx_q;
	logic signed [31:0] p_q, g_q, m_q, x_q, res_q;
	logic [31:0]        s_q, c2_pad;
	logic [16:0]        t_q, e_q, r1_q, r2_q, pb1_q, pb2_q, c2_q;
	logic [63:0]        xl_q;
	logic [47:0]        glr_s1, sqg_s1;
	logic [32:0]        gnb_s1, mb_s2, sb_s2;
	logic [48:0]        sqb_s2;

	ds_op_t      ds_op_q;
	logic [63:0] ds_num_q;
	logic [31:0] ds_den_q;
	ds_req_t     ds_req;
	ds_rsp_t     ds_rsp;

	logic [32:0] rd_a;
	logic [31:0] rd_s;
	logic        wa_we, ws_we;
	logic [ADDR_W-1:0] wa_addr;
	logic [32:0] wa_data;

	logic use_mom, is_mom, is_ada, is_rms, is_adam;
	logic [16:0] b1, b2, nb1, bx, nbx, c1;
	logic [31:0] gmag, mmag, xmag;
	logic [63:0] prod_glr, prod_sq, prod_xl;
	logic [48:0] prod_gn, prod_mb, prod_sb;
	logic [64:0] prod_sqb;
	logic [33:0] pr1, pr2, pb1sq, pb2sq;
	logic signed [63:0] p64, mb_sg, glr_sg, gnb_sg, qs;
	logic signed [31:0] mom_m, adam_m, mh;
	logic [24:0]  den25;
	logic [40:0]  qcap;
	logic pow_zero;

	assign is_mom  = (mode_q == MODE_MOMENTUM);
	assign is_ada  = (mode_q == MODE_ADAGRAD);
	assign is_rms  = (mode_q == MODE_RMSPROP);
	assign is_adam = (mode_q == MODE_ADAM);
	assign use_mom = is_mom || is_ada || is_rms || is_adam;

	assign b1  = (d1_q > ONE_Q) ? ONE_Q : d1_q;
	assign b2  = (d2_q > ONE_Q) ? ONE_Q : d2_q;
	assign nb1 = ONE_Q - b1;
	assign bx  = is_adam ? b2 : b1;
	assign nbx = ONE_Q - bx;

	assign gmag = g_q[31] ? (~g_q + 32'd1) : g_q;
	assign mmag = m_q[31] ? (~m_q + 32'd1) : m_q;
	assign xmag = x_q[31] ? (~x_q + 32'd1) : x_q;

	assign prod_glr = gmag * lr_q;
	assign prod_sq  = gmag * gmag;
	assign prod_gn  = gmag * nb1;
	assign prod_mb  = mmag * b1;
	assign prod_sb  = s_q * bx;
	assign prod_sqb = sqg_s1 * nbx;
	assign prod_xl  = xmag * lr_q;

	assign pr1   = r1_q * pb1_q;
	assign pr2   = r2_q * pb2_q;
	assign pb1sq = pb1_q * pb1_q;
	assign pb2sq = pb2_q * pb2_q;
	assign c1    = ONE_Q - r1_q;
	assign pow_zero = (c1 == '0) || ((ONE_Q - r2_q) == '0);

	assign p64    = $signed({{32{p_q[31]}}, p_q});
	assign mb_sg  = m_q[31] ? -$signed({31'b0, mb_s2}) : $signed({31'b0, mb_s2});
	assign glr_sg = g_q[31] ? -$signed({16'b0, glr_s1}) : $signed({16'b0, glr_s1});
	assign gnb_sg = g_q[31] ? -$signed({31'b0, gnb_s1}) : $signed({31'b0, gnb_s1});
	assign mom_m  = sat_s32(mb_sg + glr_sg);
	assign adam_m = sat_s32(mb_sg + gnb_sg);

	assign mh = sat_s32(m_q[31] ? -$signed(ds_rsp.res) : $signed(ds_rsp.res));
	assign den25 = {1'b0, ds_rsp.res[23:0]} + {9'b0, eps_q};
	assign qcap  = (ds_rsp.res > {23'b0, STEP_CAP}) ? STEP_CAP : ds_rsp.res[40:0];
	assign qs    = $signed({23'b0, qcap});
	assign c2_pad = {15'b0, c2_q};

	// config port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DESCENT;
			lr_q   <= 32'd655;
			d1_q   <= 17'd58982;
			d2_q   <= 17'd65470;
			eps_q  <= 16'd1;
			init_q <= 31'd6554;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[2:0];
				CFG_LR:   lr_q   <= cfg_data;
				CFG_D1:   d1_q   <= cfg_data[16:0];
				CFG_D2:   d2_q   <= cfg_data[16:0];
				CFG_EPS:  eps_q  <= cfg_data[15:0];
				CFG_INIT: init_q <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// state memories: {seen, first moment} and second moment
	assign wa_we   = (state_q == S_CLR) || ((state_q == S_WB) && use_mom);
	assign ws_we   = (state_q == S_WB) && use_mom;
	assign wa_addr = (state_q == S_CLR) ? clr_cnt_q : idx_q[ADDR_W-1:0];
	assign wa_data = (state_q == S_CLR) ? 33'b0 : {1'b1, m_q};

	gou_ram #(.WIDTH(33), .DEPTH(NUM_ELEMENTS)) u_ram_m (
		.clk   (clk),
		.we    (wa_we),
		.waddr (wa_addr),
		.wdata (wa_data),
		.raddr (in_data.element_index[ADDR_W-1:0]),
		.rdata (rd_a)
	);

	gou_ram #(.WIDTH(32), .DEPTH(NUM_ELEMENTS)) u_ram_s (
		.clk   (clk),
		.we    (ws_we),
		.waddr (idx_q[ADDR_W-1:0]),
		.wdata (s_q),
		.raddr (in_data.element_index[ADDR_W-1:0]),
		.rdata (rd_s)
	);

	assign ds_req.start = start_q;
	assign ds_req.op    = ds_op_q;
	assign ds_req.num   = ds_num_q;
	assign ds_req.den   = ds_den_q;

	gou_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ds_req),
		.rsp    (ds_rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				if (clr_cnt_q == ADDR_W'(NUM_ELEMENTS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_RD;
			end
			S_RD:  state_d = S_MUL;
			S_MUL: state_d = S_SUM;
			S_SUM: state_d = S_WB;
			S_WB: begin
				if (is_ada || is_rms) state_d = S_SQRT;
				else if (is_adam) state_d = S_POW;
				else state_d = S_OUT;
			end
			S_POW: begin
				if (e_q == '0) state_d = pow_zero ? S_OUT : S_DIV1;
			end
			S_DIV1: begin
				if (ds_rsp.done) state_d = S_DIV2;
			end
			S_DIV2: begin
				if (ds_rsp.done) state_d = S_SQRT;
			end
			S_SQRT: begin
				if (ds_rsp.done) state_d = (den25 == '0) ? S_OUT : S_DIVQ;
			end
			S_DIVQ: begin
				if (ds_rsp.done) state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_cnt_q <= '0;
			start_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			start_q <= (state_d != state_q) && ((state_d == S_DIV1) ||
				(state_d == S_DIV2) || (state_d == S_SQRT) || (state_d == S_DIVQ));
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		xl_q <= prod_xl;
		case (state_q)
			S_IDLE: begin
				idx_q <= in_data.element_index;
				p_q   <= in_data.parameter_value;
				g_q   <= in_data.gradient_value;
				t_q   <= {1'b0, in_data.step_number} + 17'd1;
			end
			S_RD: begin
				m_q    <= rd_a[32] ? rd_a[31:0] : 32'sd0;
				s_q    <= rd_a[32] ? rd_s : (is_ada ? {1'b0, init_q} : 32'd0);
				glr_s1 <= prod_glr[63:16];
				sqg_s1 <= prod_sq[63:16];
				gnb_s1 <= prod_gn[48:16];
			end
			S_MUL: begin
				mb_s2  <= prod_mb[48:16];
				sb_s2  <= prod_sb[48:16];
				sqb_s2 <= prod_sqb[64:16];
			end
			S_SUM: begin
				if (is_mom) begin
					m_q   <= mom_m;
					res_q <= sat_s32(p64 - $signed({{32{mom_m[31]}}, mom_m}));
				end else begin
					res_q <= sat_s32(p64 - glr_sg);
					if (is_ada) begin
						s_q <= usat32({32'b0, s_q} + {16'b0, sqg_s1});
					end else if (is_rms) begin
						s_q <= usat32({31'b0, sb_s2} + {15'b0, sqb_s2});
					end else if (is_adam) begin
						m_q <= adam_m;
						s_q <= usat32({31'b0, sb_s2} + {15'b0, sqb_s2});
					end
				end
			end
			S_WB: begin
				x_q      <= g_q;
				ds_op_q  <= OP_SQRT;
				ds_num_q <= {s_q, 32'b0};
				ds_den_q <= '0;
				e_q      <= t_q;
				r1_q     <= ONE_Q;
				r2_q     <= ONE_Q;
				pb1_q    <= b1;
				pb2_q    <= b2;
			end
			S_POW: begin
				if (e_q == '0) begin
					res_q    <= p_q;
					c2_q     <= ONE_Q - r2_q;
					ds_op_q  <= OP_DIV;
					ds_num_q <= {16'b0, mmag, 16'b0};
					ds_den_q <= {15'b0, c1};
				end else begin
					if (e_q[0]) begin
						r1_q <= pr1[32:16];
						r2_q <= pr2[32:16];
					end
					pb1_q <= pb1sq[32:16];
					pb2_q <= pb2sq[32:16];
					e_q   <= e_q >> 1;
				end
			end
			S_DIV1: begin
				if (ds_rsp.done) begin
					x_q      <= mh;
					ds_op_q  <= OP_DIV;
					ds_num_q <= {16'b0, s_q, 16'b0};
					ds_den_q <= c2_pad;
				end
			end
			S_DIV2: begin
				if (ds_rsp.done) begin
					ds_op_q  <= OP_SQRT;
					ds_num_q <= {usat32(ds_rsp.res), 32'b0};
				end
			end
			S_SQRT: begin
				if (ds_rsp.done) begin
					res_q    <= p_q;
					ds_op_q  <= OP_DIV;
					ds_num_q <= xl_q;
					ds_den_q <= {7'b0, den25};
				end
			end
			S_DIVQ: begin
				if (ds_rsp.done) begin
					res_q <= sat_s32(x_q[31] ? (p64 + qs) : (p64 - qs));
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data.result_index  = idx_q;
	assign out_data.updated_value = res_q;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import gou_pkg::*;

	localparam logic [2:0] MODE_UNDEF_FIRST = MODE_ADAM + 3'd1;
	localparam logic [2:0] MODE_UNDEF_LAST  = 3'd7;
	localparam int SETTLE_CYCLES = 120;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	// shadow of the block's registers and moment memories
	logic [2:0]  mode_r;
	logic [63:0] lr_r, d1_r, d2_r, eps_r, init_r;
	longint      first_mem [NUM_ELEMENTS];
	logic [63:0] second_mem [NUM_ELEMENTS];
	bit          seen_mem [NUM_ELEMENTS];

	in_item_t    pending_items[$];
	out_item_t   expected_updates[$];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          mismatch_count;
	int          updates_checked;

	gradient_optimizer_update u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clamp_s32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic [63:0] clamp_u32(logic [63:0] v);
		return v > 64'hffff_ffff ? 64'hffff_ffff : v;
	endfunction

	// Q16.16 product, truncated toward zero
	function automatic longint qmul(longint a, logic [63:0] k);
		logic [63:0] m;
		m = (magnitude(a) * k) >> 16;
		return a < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] decay_power(logic [63:0] base, logic [63:0] e);
		logic [63:0] r;
		r = 64'd65536;
		while (e != 0) begin
			if (e[0]) r = (r * base) >> 16;
			base = (base * base) >> 16;
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic longint apply_scaled_step(longint p, longint x, logic [63:0] den);
		logic [63:0] q;
		if (den == 0) return p;
		q = (magnitude(x) * lr_r) / den;
		if (q > 64'(STEP_CAP)) q = 64'(STEP_CAP);
		return clamp_s32(x < 0 ? p + longint'(q) : p - longint'(q));
	endfunction

	function automatic out_item_t predict_update(in_item_t it);
		int unsigned a;
		longint      p, g, m, res, mh;
		logic [63:0] s, t, b1, b2, gsq, c1, c2, vh;
		out_item_t   o;
		a = it.element_index % NUM_ELEMENTS;
		p = it.parameter_value;
		g = it.gradient_value;
		t = 64'(it.step_number) + 1;
		b1 = d1_r > 65536 ? 64'd65536 : d1_r;
		b2 = d2_r > 65536 ? 64'd65536 : d2_r;
		gsq = (magnitude(g) * magnitude(g)) >> 16;
		res = p;
		if (mode_r >= MODE_MOMENTUM && mode_r <= MODE_ADAM) begin
			if (seen_mem[a]) begin
				m = first_mem[a];
				s = second_mem[a];
			end else begin
				m = 0;
				s = (mode_r == MODE_ADAGRAD) ? init_r : 64'd0;
			end
			case (mode_r)
				MODE_MOMENTUM: begin
					m = clamp_s32(qmul(m, b1) + qmul(g, lr_r));
					res = clamp_s32(p - m);
				end
				MODE_ADAGRAD: begin
					s = clamp_u32(s + gsq);
					res = apply_scaled_step(p, g, floor_sqrt(s << 16) + eps_r);
				end
				MODE_RMSPROP: begin
					s = clamp_u32(((s * b1) >> 16) + ((gsq * (65536 - b1)) >> 16));
					res = apply_scaled_step(p, g, floor_sqrt(s << 16) + eps_r);
				end
				default: begin
					m = clamp_s32(qmul(m, b1) + qmul(g, 65536 - b1));
					s = clamp_u32(((s * b2) >> 16) + ((gsq * (65536 - b2)) >> 16));
					c1 = 65536 - decay_power(b1, t);
					c2 = 65536 - decay_power(b2, t);
					if (c1 != 0 && c2 != 0) begin
						mh = longint'((magnitude(m) << 16) / c1);
						mh = clamp_s32(m < 0 ? -mh : mh);
						vh = clamp_u32((s << 16) / c2);
						res = apply_scaled_step(p, mh, floor_sqrt(vh << 16) + eps_r);
					end
				end
			endcase
			first_mem[a] = longint'(signed'(m[31:0]));
			second_mem[a] = {32'd0, s[31:0]};
			seen_mem[a] = 1'b1;
		end else begin
			res = clamp_s32(p - qmul(g, lr_r));
		end
		o.result_index = it.element_index;
		o.updated_value = res[31:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// sender: present items from the pending queue, predict on each transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_updates.push_back(predict_update(in_data));
				void'(pending_items.pop_front());
			end
			if (in_valid && !in_ready) begin
				in_valid <= 1'b1;
			end else if (pending_items.size() > 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_items[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: check each result transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_updates.size() == 0) begin
					report_mismatch("unexpected result, index", out_data.result_index, -1);
				end else begin
					if (out_data.result_index !== expected_updates[0].result_index)
						report_mismatch("result_index", out_data.result_index,
							expected_updates[0].result_index);
					if (out_data.updated_value !== expected_updates[0].updated_value)
						report_mismatch("updated_value", out_data.updated_value,
							expected_updates[0].updated_value);
					void'(expected_updates.pop_front());
					updates_checked++;
				end
			end
			out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MODE: mode_r = value[2:0];
			CFG_LR:   lr_r = 64'(value);
			CFG_D1:   d1_r = 64'(value[16:0]);
			CFG_D2:   d2_r = 64'(value[16:0]);
			CFG_EPS:  eps_r = 64'(value[15:0]);
			CFG_INIT: init_r = 64'(value[30:0]);
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || expected_updates.size() != 0 || in_valid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_item(int idx, longint p, longint g, int step);
		in_item_t it;
		it.element_index = idx[9:0];
		it.parameter_value = p[31:0];
		it.gradient_value = g[31:0];
		it.step_number = step[15:0];
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] random_q(int sel);
		case (sel)
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom();
			default: return 32'($urandom_range(0, 2097151)) - 32'd1048576;
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int       r;
		it.element_index = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 31))
			: 10'($urandom_range(0, 1023));
		it.parameter_value = random_q($urandom_range(0, 5));
		it.gradient_value = random_q($urandom_range(0, 5));
		r = $urandom_range(0, 9);
		it.step_number = (r < 7) ? 16'($urandom_range(0, 30)) :
			(r == 7) ? 16'hffff : 16'($urandom());
		return it;
	endfunction

	function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi,
			logic [31:0] rnd, logic [31:0] typical);
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			2: return rnd;
			default: return typical;
		endcase
	endfunction

	initial begin
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatch_count = 0;
		updates_checked = 0;
		mode_r = MODE_DESCENT;
		lr_r = 655;
		d1_r = 58982;
		d2_r = 65470;
		eps_r = 1;
		init_r = 6554;
		for (int i = 0; i < NUM_ELEMENTS; i++) begin
			first_mem[i] = 0;
			second_mem[i] = 0;
			seen_mem[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes in descent at reset settings
		queue_item(0, 0, 0, 0);
		queue_item(1023, 32'sh7fff_ffff, -64'sd2147483648, 65535);
		queue_item(512, -64'sd2147483648, 64'sd2147483647, 0);
		drain();
		write_reg(CFG_LR, 32'hffff_ffff);
		queue_item(3, 65536, 65536, 1);
		drain();
		// undefined modes act as descent
		write_reg(CFG_MODE, MODE_UNDEF_FIRST);
		queue_item(4, 100, -200, 2);
		drain();
		write_reg(CFG_MODE, MODE_UNDEF_LAST);
		queue_item(4, -100, 200, 2);
		drain();
		// momentum with decay above one; first visit then revisit
		write_reg(CFG_LR, 65536);
		write_reg(CFG_D1, 32'h1ffff);
		write_reg(CFG_MODE, MODE_MOMENTUM);
		queue_item(5, 0, -64'sd2147483648, 0);
		queue_item(5, 1000, -64'sd2147483648, 1);
		drain();
		// adagrad with zero start and zero guard: zero denominator
		write_reg(CFG_INIT, 0);
		write_reg(CFG_EPS, 0);
		write_reg(CFG_MODE, MODE_ADAGRAD);
		queue_item(7, 12345, 0, 0);
		queue_item(7, 12345, 65536, 0);
		drain();
		// rmsprop reuses moments left by adagrad
		write_reg(CFG_D1, 0);
		write_reg(CFG_EPS, 65535);
		write_reg(CFG_MODE, MODE_RMSPROP);
		queue_item(7, -5000, 3000, 0);
		drain();
		// adam with beta1 of one: zero bias correction
		write_reg(CFG_D1, 65536);
		write_reg(CFG_MODE, MODE_ADAM);
		queue_item(9, 777, 65536, 0);
		drain();
		write_reg(CFG_D1, 58982);
		write_reg(CFG_D2, 65470);
		write_reg(CFG_EPS, 1);
		queue_item(9, 777, 65536, 0);
		queue_item(9, 777, -131072, 65535);
		queue_item(10, 0, 64'sd2147483647, 3);
		drain();

		// random phases, all registers rewritten each time
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 59; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 59; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			write_reg(CFG_MODE, 3'((ph * 3) % 8));
			write_reg(CFG_LR, pick(0, 32'hffff_ffff, $urandom(), $urandom_range(1, 8192)));
			write_reg(CFG_D1, pick(0, 65536, $urandom_range(0, 131071),
				$urandom_range(52000, 65535)));
			write_reg(CFG_D2, pick(0, 65536, $urandom_range(0, 131071),
				$urandom_range(60000, 65535)));
			write_reg(CFG_EPS, pick(0, 65535, $urandom_range(0, 65535),
				$urandom_range(0, 16)));
			write_reg(CFG_INIT, pick(0, 32'h7fff_ffff, $urandom_range(0, 32'h7fff_ffff),
				$urandom_range(0, 65536)));
			n = 100;
			for (int k = 0; k < n; k++) pending_items.push_back(random_item());
			drain();
		end

		$display("Covered all five modes plus undefined modes over 16 random settings;");
		$display("%0d results checked under mixed sender and receiver idling.",
			updates_checked);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

endmodule
